// File: rtl/gdh_pkg.sv
// Shared types, constants and handshake structs for the graph degree histogram.
`timescale 1ns / 1ps
`default_nettype none
package gdh_pkg;

   // Default node capacity of the degree store.
   localparam int MAX_NODES_DEF = 1024;

   // Field widths of the request and response beats.
   localparam int CMD_W        = 2;
   localparam int NODE_W       = 10;
   localparam int BIN_W        = 11;
   localparam int COUNT_W      = 32;
   localparam int NODE_COUNT_W = 11;

   // Request beat layout, lowest bits first.
   localparam int CMD_LSB  = 0;
   localparam int NODE_LSB = CMD_LSB + CMD_W;
   localparam int BIN_LSB  = NODE_LSB + NODE_W;
   localparam int REQ_USED = BIN_LSB + BIN_W;
   localparam int REQ_W    = ((REQ_USED + 7) / 8) * 8;

   // Response beat layout, lowest bits first.
   localparam int RSP_USED = BIN_W + COUNT_W;
   localparam int RSP_W    = ((RSP_USED + 7) / 8) * 8;
   localparam int RSP_PAD  = RSP_W - RSP_USED;

   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_EDGE   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_WR,
      ST_SW_RD,
      ST_SW_BIN,
      ST_SW_WR,
      ST_READ_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;
      logic addr_from_req;
      logic deg_rd_en;
      logic bin_rd_en;
      logic cnt_start;
      logic cnt_inc;
      logic deg_wr_inc;
      logic deg_wr_zero;
      logic bin_wr_inc;
      logic bin_wr_zero;
      logic out_load;
   } ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      cmd_type req_cmd;
      logic    node_ok;
      logic    cnt_done;
      logic    clr_last;
      logic    out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/gdh_datapath.sv
// Datapath of the graph degree histogram: both stores, the sweep counter and the result register.
`timescale 1ns / 1ps
`default_nettype none
module gdh_datapath #(
   parameter int MAX_NODES = gdh_pkg::MAX_NODES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [gdh_pkg::REQ_W-1:0]         req_tdata,
   input  wire logic                              csr_valid,
   input  wire logic [gdh_pkg::NODE_COUNT_W-1:0]  csr_data,
   input  wire gdh_pkg::ctl_type                  ctl,
   output gdh_pkg::sts_type                       sts,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [gdh_pkg::RSP_W-1:0]              rsp_tdata
);
   import gdh_pkg::*;

   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int BIN_AW    = $clog2(MAX_NODES + 1);
   localparam int BIN_DEPTH = MAX_NODES + 1;
   localparam logic [BIN_AW-1:0]  CNT_MAX = BIN_AW'(MAX_NODES);
   localparam logic [COUNT_W-1:0] BIN_SAT = '1;

   logic [BIN_AW-1:0]  deg_mem [MAX_NODES];
   logic [COUNT_W-1:0] bin_mem [BIN_DEPTH];

   logic [NODE_COUNT_W-1:0] node_count_ff;
   logic [BIN_AW-1:0]       cnt_ff, cnt_in;
   logic [BIN_AW-1:0]       limit_ff, limit_in;
   logic [NODE_AW-1:0]      node_addr_ff;
   logic [BIN_W-1:0]        bin_degree_ff;
   logic                    bin_ok_ff;
   logic [BIN_AW-1:0]       deg_rd_ff;
   logic [COUNT_W-1:0]      bin_rd_ff;
   logic                    rsp_tvalid_ff;
   logic [RSP_W-1:0]        rsp_tdata_ff;

   logic [31:0]        node32, bin32, lim32;
   logic [NODE_W-1:0]  node_in;
   logic [BIN_W-1:0]   bin_in;
   logic               bin_ok;
   logic [NODE_AW-1:0] deg_raddr, deg_waddr;
   logic [BIN_AW-1:0]  bin_raddr, bin_waddr;
   logic [BIN_AW-1:0]  deg_wdata, deg_sat_inc;
   logic [COUNT_W-1:0] bin_wdata, bin_sat_inc, bin_count;
   logic               deg_we, bin_we;

   // Request field decode.
   assign node_in = req_tdata[NODE_LSB +: NODE_W];
   assign bin_in  = req_tdata[BIN_LSB +: BIN_W];
   assign node32  = 32'(node_in);
   assign bin32   = 32'(bin_in);
   assign bin_ok  = bin32 <= 32'(MAX_NODES);

   assign sts.req_cmd  = cmd_type'(req_tdata[CMD_LSB +: CMD_W]);
   assign sts.node_ok  = node32 < 32'(MAX_NODES);
   assign sts.cnt_done = cnt_ff == limit_ff;
   assign sts.clr_last = cnt_ff == CNT_MAX;
   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

   // The sweep covers at most MAX_NODES counters.
   assign lim32    = (32'(node_count_ff) < 32'(MAX_NODES)) ? 32'(node_count_ff)
                                                           : 32'(MAX_NODES);
   assign limit_in = lim32[BIN_AW-1:0];

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.cnt_start) begin
         cnt_in = '0;
      end else if (ctl.cnt_inc) begin
         cnt_in = cnt_ff + BIN_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         cnt_ff        <= '0;
         limit_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            node_count_ff <= csr_data;
         end
         cnt_ff <= cnt_in;
         if (ctl.cnt_start) begin
            limit_ff <= limit_in;
         end
         if (ctl.out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Captured request payload.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         node_addr_ff  <= node32[NODE_AW-1:0];
         bin_degree_ff <= bin_in;
         bin_ok_ff     <= bin_ok;
      end
   end

   // Store addressing and saturating updates.
   assign deg_raddr   = ctl.addr_from_req ? node32[NODE_AW-1:0] : cnt_ff[NODE_AW-1:0];
   assign bin_raddr   = ctl.addr_from_req ? bin32[BIN_AW-1:0] : deg_rd_ff;
   assign deg_sat_inc = (deg_rd_ff == CNT_MAX) ? deg_rd_ff : deg_rd_ff + BIN_AW'(1);
   assign bin_sat_inc = (bin_rd_ff == BIN_SAT) ? bin_rd_ff : bin_rd_ff + COUNT_W'(1);

   assign deg_we    = ctl.deg_wr_inc || (ctl.deg_wr_zero && (cnt_ff != CNT_MAX));
   assign deg_waddr = ctl.deg_wr_inc ? node_addr_ff : cnt_ff[NODE_AW-1:0];
   assign deg_wdata = ctl.deg_wr_inc ? deg_sat_inc : '0;

   assign bin_we    = ctl.bin_wr_inc || ctl.bin_wr_zero;
   assign bin_waddr = ctl.bin_wr_inc ? deg_rd_ff : cnt_ff;
   assign bin_wdata = ctl.bin_wr_inc ? bin_sat_inc : '0;

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_waddr] <= deg_wdata;
      end
      if (ctl.deg_rd_en) begin
         deg_rd_ff <= deg_mem[deg_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      if (ctl.bin_rd_en) begin
         bin_rd_ff <= bin_mem[bin_raddr];
      end
   end

   // Result register.
   assign bin_count = bin_ok_ff ? bin_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_tdata_ff <= {RSP_PAD'(0), bin_count, bin_degree_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register loaded while a beat is pending");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("sweep counter beyond the store depth");

   a_deg_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.deg_wr_inc, ctl.deg_wr_zero}))
      else $error("two writers on the degree store");

   a_bin_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.bin_wr_inc, ctl.bin_wr_zero}))
      else $error("two writers on the bin store");

   a_sweep_in_limit: assert property (@(posedge clock) disable iff (reset)
      ctl.bin_wr_inc |-> (cnt_ff < limit_ff))
      else $error("sweep update past the node limit");
`endif

endmodule
`default_nettype wire

// File: rtl/gdh_controller.sv
// Controller state machine of the graph degree histogram.
`timescale 1ns / 1ps
`default_nettype none
module gdh_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire gdh_pkg::sts_type sts,
   output gdh_pkg::ctl_type      ctl
);
   import gdh_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.deg_wr_zero = 1'b1;
            ctl.bin_wr_zero = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end else begin
               ctl.cnt_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready        = 1'b1;
            ctl.addr_from_req = 1'b1;
            ctl.deg_rd_en     = 1'b1;
            ctl.bin_rd_en     = 1'b1;
            if (req_tvalid) begin
               ctl.accept = 1'b1;
               case (sts.req_cmd)
                  CMD_EDGE: begin
                     if (sts.node_ok) begin
                        state_in = ST_EDGE_WR;
                     end
                  end
                  CMD_SAMPLE: begin
                     ctl.cnt_start = 1'b1;
                     state_in      = ST_SW_RD;
                  end
                  CMD_READ: begin
                     state_in = ST_READ_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EDGE_WR: begin
            ctl.deg_wr_inc = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SW_RD: begin
            if (sts.cnt_done) begin
               state_in = ST_IDLE;
            end else begin
               ctl.deg_rd_en = 1'b1;
               state_in      = ST_SW_BIN;
            end
         end
         ST_SW_BIN: begin
            ctl.bin_rd_en = 1'b1;
            state_in      = ST_SW_WR;
         end
         ST_SW_WR: begin
            ctl.bin_wr_inc  = 1'b1;
            ctl.deg_wr_zero = 1'b1;
            ctl.cnt_inc     = 1'b1;
            state_in        = ST_SW_RD;
         end
         ST_READ_OUT: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/graph_degree_histogram.sv
// Top level of the graph degree histogram: controller and datapath.
//
// Request channel (req_*): one beat per command. An edge beat adds one to the
// degree counter of node_index, saturating at MAX_NODES. A sample beat sweeps
// the first min(node_count, MAX_NODES) degree counters into the distribution
// bins and clears them. A read beat returns one bin on the response channel.
// Response channel (rsp_*): one beat per read, carrying the bin index and its
// saturating count; bins above MAX_NODES read as zero. Edge and sample beats
// and the unused command code produce no response.
// Configuration (csr_*): node_count, always ready; write it only while idle.
// Sequencing: an edge or read passes through its write or read-out state
// before idle; an ignored edge or unused code is dropped in idle. A sample
// steps through the read, read, write sequence per swept node, each step
// waiting on the last. A read result is loaded into the output register
// from the read-out state, which waits while a beat is pending.
// Reset: both stores are cleared by a pass over every address up to MAX_NODES,
// during which req_tready stays low; node_count returns to 1024.
// Stall: a pending response beat sits in the output register while further
// edge and sample beats proceed; a second read waits for that beat to drain.
`timescale 1ns / 1ps
`default_nettype none
module graph_degree_histogram #(
   parameter int MAX_NODES = gdh_pkg::MAX_NODES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // req_tdata fields, lowest bit up: command[1:0], node_index[11:2],
   // bin_index[22:12], zero pad[23].
   input  wire logic [gdh_pkg::REQ_W-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata fields, lowest bit up: bin_degree[10:0], bin_count[42:11],
   // zero pad[47:43].
   output logic [gdh_pkg::RSP_W-1:0]             rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gdh_pkg::NODE_COUNT_W-1:0] csr_data
);
   import gdh_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // The node_count register takes a write beat in every cycle.
   assign csr_ready = 1'b1;

   gdh_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   gdh_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: bench/gdh_checker.sv
// Checker for the graph degree histogram: tracks both stores and compares every read reply.
`timescale 1ns / 1ps
module gdh_checker #(
   parameter int MAX_NODES = gdh_pkg::MAX_NODES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [gdh_pkg::REQ_W-1:0]        req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [gdh_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [gdh_pkg::NODE_COUNT_W-1:0] csr_data,
   output int                               error_count,
   output int                               pending_reads
);
   import gdh_pkg::*;

   typedef struct packed {
      logic [BIN_W-1:0]   degree;
      logic [COUNT_W-1:0] count;
   } bin_reply_type;

   logic [BIN_W-1:0]        node_degree [MAX_NODES];
   logic [COUNT_W-1:0]      degree_bins [MAX_NODES+1];
   logic [NODE_COUNT_W-1:0] node_count_reg;
   bin_reply_type           expected_replies [$];

   initial begin
      error_count   = 0;
      pending_reads = 0;
   end

   // End of sample: every swept node lands in the bin of its degree and starts over.
   task automatic sweep_degrees();
      int limit;
      int d;
      limit = (int'(node_count_reg) > MAX_NODES) ? MAX_NODES : int'(node_count_reg);
      for (int n = 0; n < limit; n++) begin
         d = int'(node_degree[n]);
         if (d > MAX_NODES) d = MAX_NODES;
         if (degree_bins[d] != '1) degree_bins[d] = degree_bins[d] + COUNT_W'(1);
         node_degree[n] = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      logic [CMD_W-1:0]  req_cmd;
      logic [NODE_W-1:0] req_node;
      logic [BIN_W-1:0]  req_bin;
      bin_reply_type     reply;
      bin_reply_type     seen;
      if (reset) begin
         for (int n = 0; n < MAX_NODES; n++) node_degree[n] = '0;
         for (int b = 0; b <= MAX_NODES; b++) degree_bins[b] = '0;
         node_count_reg = NODE_COUNT_RESET;
         expected_replies.delete();
      end else begin
         if (csr_valid && csr_ready) node_count_reg = csr_data;

         if (rsp_tvalid && rsp_tready) begin
            seen.degree = rsp_tdata[0 +: BIN_W];
            seen.count  = rsp_tdata[BIN_W +: COUNT_W];
            if (expected_replies.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: reply beat with no read outstanding: degree %0d count %0d",
                           $realtime, seen.degree, seen.count);
               error_count = error_count + 1;
            end else begin
               reply = expected_replies.pop_front();
               if (seen.degree !== reply.degree || seen.count !== reply.count) begin
                  if (error_count < 10)
                     $display("%0t: bin read mismatch: degree exp %0d got %0d, count exp %0d got %0d",
                              $realtime, reply.degree, seen.degree, reply.count, seen.count);
                  error_count = error_count + 1;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            req_cmd  = req_tdata[CMD_LSB +: CMD_W];
            req_node = req_tdata[NODE_LSB +: NODE_W];
            req_bin  = req_tdata[BIN_LSB +: BIN_W];
            case (req_cmd)
               CMD_EDGE: begin
                  if (int'(req_node) < MAX_NODES && int'(node_degree[req_node]) < MAX_NODES)
                     node_degree[req_node] = node_degree[req_node] + BIN_W'(1);
               end
               CMD_SAMPLE: begin
                  sweep_degrees();
               end
               CMD_READ: begin
                  reply.degree = req_bin;
                  if (int'(req_bin) <= MAX_NODES) reply.count = degree_bins[req_bin];
                  else reply.count = '0;
                  expected_replies.push_back(reply);
               end
               default: begin
               end
            endcase
         end
      end
      pending_reads = expected_replies.size();
   end

endmodule

// File: bench/tb_top.sv
// Testbench top for the graph degree histogram: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_top;
   import gdh_pkg::*;

   localparam int MAX_NODES = MAX_NODES_DEF;

   // The unused command code; the block must swallow it without a reply.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Settle time that covers one full sweep at full size.
   localparam int SWEEP_SETTLE = 3 * MAX_NODES + 16;

   // Length of the one long stall on the reply side.
   localparam int LONG_HOLD = 600;

   // Random items per configuration phase.
   localparam int PHASE_ITEMS = 100;

   // Hard stop, well beyond the slowest correct run including the clearing pass.
   localparam longint TIMEOUT_NS = 64'd12 * 64'd1_200_000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_W-1:0]        rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [NODE_COUNT_W-1:0] csr_data;

   int   error_count;
   int   pending_reads;

   // When set, neither side inserts gaps; changed only at clock edges.
   logic quiet_mode;
   // Each increment asks the reply side for one long hold-off.
   int   hold_asked;

   graph_degree_histogram #(.MAX_NODES(MAX_NODES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   gdh_checker #(.MAX_NODES(MAX_NODES)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_reads (pending_reads)
   );

   // 12 ns clock period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offers one request beat after a random gap and returns at the edge where
   // the beat is taken. The fields are packed from the lowest bit up, with the
   // pad bit left at zero. Every drive happens with a nonblocking assignment at
   // a rising edge, so the block and the checker both see the values of the
   // previous cycle at each edge.
   task automatic send_beat(input logic [CMD_W-1:0] cmd,
                            input int               node,
                            input int               bin);
      logic [REQ_W-1:0] beat;
      int               gap;
      beat = '0;
      beat[CMD_LSB +: CMD_W]   = cmd;
      beat[NODE_LSB +: NODE_W] = NODE_W'(node);
      beat[BIN_LSB +: BIN_W]   = BIN_W'(bin);
      gap = quiet_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Writes node_count through the configuration channel.
   task automatic write_node_count(input int value);
      csr_valid <= 1'b1;
      csr_data  <= NODE_COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering beats and waits until every read has been answered. The
   // checker updates its count at the rising edge, so it is sampled on the
   // falling edge. A sample beat gives no reply, so a sweep may still be
   // running when the last reply arrives; the settle count covers that before
   // the configuration is touched.
   task automatic drain_replies(input int settle);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_reads != 0) @(negedge clock);
      @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Reply side: a random gap before each beat, plus one long hold-off on
   // request. During the hold-off a second read cannot leave the block, so
   // the request side backs up while the sender keeps offering beats.
   initial begin : reply_side
      int gap;
      int hold_done;
      hold_done  = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = quiet_mode ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // Main stimulus: a directed opening, then random phases over several
   // node_count settings, then the verdict.
   initial begin : stimulus
      int node_count_list [$];
      int eff;
      int roll;
      int sample_pct;
      int pick;
      int node;
      int bin_sel;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet_mode = 1'b0;
      hold_asked = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // After the clearing pass every bin reads zero, including the top bin
      // and bins beyond the store, which report their index with a zero count.
      send_beat(CMD_READ, $urandom, 0);
      send_beat(CMD_READ, $urandom, MAX_NODES);
      send_beat(CMD_READ, $urandom, 'h7FF);
      send_beat(CMD_READ, $urandom, MAX_NODES + 1);
      // The unused code must leave both stores alone.
      send_beat(CMD_UNUSED, $urandom, $urandom);

      // A few degrees at both ends of the node range.
      send_beat(CMD_EDGE, 0, $urandom);
      send_beat(CMD_EDGE, 'h3FF, $urandom);
      send_beat(CMD_EDGE, 'h3FF, $urandom);
      repeat (3) send_beat(CMD_EDGE, 5, $urandom);

      // Drive one node past the largest degree so its counter saturates and
      // lands in the top bin at the sweep. Back to back to keep it short.
      quiet_mode <= 1'b1;
      repeat (MAX_NODES + 6) send_beat(CMD_EDGE, 7, $urandom);
      quiet_mode <= 1'b0;

      // Full sweep at the reset node_count, then the bins it touched.
      send_beat(CMD_SAMPLE, $urandom, $urandom);
      send_beat(CMD_READ, $urandom, 0);
      send_beat(CMD_READ, $urandom, 1);
      send_beat(CMD_READ, $urandom, 2);
      send_beat(CMD_READ, $urandom, 3);
      send_beat(CMD_READ, $urandom, MAX_NODES);
      // A second sweep finds every counter cleared.
      send_beat(CMD_SAMPLE, $urandom, $urandom);
      send_beat(CMD_READ, $urandom, 0);

      // With node_count zero a sweep touches nothing; the degree survives.
      drain_replies(SWEEP_SETTLE);
      write_node_count(0);
      send_beat(CMD_EDGE, 0, $urandom);
      send_beat(CMD_EDGE, 0, $urandom);
      send_beat(CMD_SAMPLE, $urandom, $urandom);
      send_beat(CMD_READ, $urandom, 2);

      // The largest node_count is capped at the store size.
      drain_replies(SWEEP_SETTLE);
      write_node_count('h7FF);
      send_beat(CMD_SAMPLE, $urandom, $urandom);
      send_beat(CMD_READ, $urandom, 2);
      send_beat(CMD_READ, $urandom, 0);

      // Random phases. Edges mostly hit the swept nodes so that degrees build
      // up between sweeps, and reads mostly look at the low bins they feed.
      node_count_list = '{1, 3, 16, 2047, 0, 64, 1024, 5, 200, 2};
      foreach (node_count_list[p]) begin
         drain_replies(SWEEP_SETTLE);
         write_node_count(node_count_list[p]);
         eff = (node_count_list[p] > MAX_NODES) ? MAX_NODES : node_count_list[p];
         sample_pct = (eff >= 200) ? 1 : 6;
         quiet_mode <= (p % 4 == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 20) hold_asked <= hold_asked + 1;
            // Halfway through, the sender waits for every reply.
            if (i == PHASE_ITEMS / 2) drain_replies(0);
            roll = $urandom_range(0, 99);
            if (roll < sample_pct) begin
               send_beat(CMD_SAMPLE, $urandom, $urandom);
            end else if (roll < sample_pct + 4) begin
               send_beat(CMD_UNUSED, $urandom, $urandom);
            end else if (roll < sample_pct + 30) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) bin_sel = $urandom_range(0, 12);
               else if (pick < 7) bin_sel = MAX_NODES;
               else if (pick < 8) bin_sel = $urandom_range(0, 200);
               else bin_sel = $urandom_range(0, 2047);
               send_beat(CMD_READ, $urandom, bin_sel);
            end else begin
               if (eff > 0 && $urandom_range(0, 6) != 0) node = $urandom_range(0, eff - 1);
               else node = $urandom;
               send_beat(CMD_EDGE, node, $urandom);
            end
         end
      end

      // Let the last replies arrive and any sweep finish before judging.
      drain_replies(SWEEP_SETTLE);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: a lost reply or a hung handshake ends up here.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
